// ----- hw/rtl/dnsp_pkg.sv -----
package dnsp_pkg;

  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = 16;

  localparam logic [15:0] ServerPortReset = 16'd53;
  localparam logic [4:0]  HeaderLastIdx   = 5'd11;
  localparam logic [4:0]  AncountHiIdx    = 5'd6;
  localparam logic [4:0]  AncountLoIdx    = 5'd7;
  localparam logic [4:0]  TailOffMax      = 5'd31;
  localparam logic [4:0]  RdlenHiOff      = 5'd15;
  localparam logic [4:0]  RdlenLoOff      = 5'd16;
  localparam logic [4:0]  AddrFirstOff    = 5'd17;
  localparam logic [4:0]  AddrLastOff     = 5'd20;
  localparam logic [7:0]  PtrMask         = 8'hC0;
  localparam logic [15:0] ARecordLength   = 16'd4;

  typedef enum logic [1:0] {
    REG_EXPECTED_TID  = 2'd0,
    REG_SERVER_PORT   = 2'd1,
    REG_LISTEN_ENABLE = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    STAT_RESOLVED   = 2'd0,
    STAT_NO_ANSWER  = 2'd1,
    STAT_BAD_ANSWER = 2'd2,
    STAT_BAD_LENGTH = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_NAME   = 2'd1,
    PH_TAIL   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] source_port;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] resolved_address;
  } out_word_t;

  typedef struct packed {
    logic [15:0] expected_tid;
    logic [15:0] server_port;
    logic        listen_enable;
  } cfg_t;

endpackage

// ----- hw/rtl/dnsp_parser.sv -----
module dnsp_parser
  import dnsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      in_fire,
  input  in_word_t  in_word,
  output logic      res_valid,
  output out_word_t res_word
);

  phase_t      phase, phase_next;
  logic [4:0]  offset, offset_next;
  logic [7:0]  skip_count, skip_count_next;
  logic        accepted, accepted_next;
  logic        answer_present, answer_present_next;
  logic [15:0] header_tid, header_tid_next;
  logic [15:0] record_length, record_length_next;
  logic [31:0] address_shift, address_shift_next;

  logic        first_byte;
  logic [7:0]  b;
  logic [4:0]  tail_off;
  logic        emit;
  status_t     status;

  assign b          = in_word.data_byte;
  assign first_byte = (phase == PH_HEADER) && (offset == '0);
  assign tail_off   = (offset < TailOffMax) ? offset + 5'd1 : TailOffMax;

  // Phase sequencing over the datagram.
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HEADER: begin
        if (offset >= HeaderLastIdx) phase_next = PH_NAME;
      end
      PH_NAME: begin
        if (skip_count == '0 && b == '0) phase_next = PH_TAIL;
      end
      PH_TAIL: phase_next = PH_TAIL;
      default: phase_next = PH_HEADER;
    endcase
  end

  // Field capture for the byte at hand.
  always_comb begin
    offset_next         = offset;
    skip_count_next     = first_byte ? '0 : skip_count;
    accepted_next       = first_byte ? (in_word.source_port == cfg.server_port) : accepted;
    answer_present_next = first_byte ? 1'b0 : answer_present;
    header_tid_next     = first_byte ? '0 : header_tid;
    record_length_next  = first_byte ? '0 : record_length;
    address_shift_next  = first_byte ? '0 : address_shift;
    case (phase)
      PH_HEADER: begin
        if (offset == 5'd0) header_tid_next = {b, 8'h00};
        else if (offset == 5'd1) header_tid_next = {header_tid_next[15:8], b};
        else if ((offset == AncountHiIdx || offset == AncountLoIdx) && b != '0)
          answer_present_next = 1'b1;
        offset_next = (offset >= HeaderLastIdx) ? '0 : offset + 5'd1;
      end
      PH_NAME: begin
        if (skip_count != '0) skip_count_next = skip_count - 8'd1;
        else if (b == '0) offset_next = '0;
        else if ((b & PtrMask) == PtrMask) skip_count_next = 8'd1;
        else skip_count_next = b;
      end
      PH_TAIL: begin
        offset_next = tail_off;
        if (tail_off == RdlenHiOff) record_length_next = {b, 8'h00};
        else if (tail_off == RdlenLoOff) record_length_next = {record_length[15:8], b};
        else if (tail_off >= AddrFirstOff && tail_off <= AddrLastOff)
          address_shift_next = {address_shift[23:0], b};
      end
      default: offset_next = '0;
    endcase
  end

  // Verdict on the final byte, from the values after this byte.
  always_comb begin
    emit = accepted_next && cfg.listen_enable && (phase_next != PH_HEADER) &&
           (header_tid_next == cfg.expected_tid);
    if (!answer_present_next) status = STAT_NO_ANSWER;
    else if (phase_next == PH_NAME || offset_next < RdlenLoOff) status = STAT_BAD_ANSWER;
    else if (record_length_next != ARecordLength || offset_next < AddrLastOff)
      status = STAT_BAD_LENGTH;
    else status = STAT_RESOLVED;
    res_valid = in_fire && in_word.last_byte && emit;
    res_word.status = status;
    res_word.resolved_address = (status == STAT_RESOLVED) ? address_shift_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      offset         <= '0;
      skip_count     <= '0;
      accepted       <= 1'b0;
      answer_present <= 1'b0;
      header_tid     <= '0;
      record_length  <= '0;
      address_shift  <= '0;
    end else if (in_fire) begin
      answer_present <= answer_present_next;
      header_tid     <= header_tid_next;
      record_length  <= record_length_next;
      address_shift  <= address_shift_next;
      if (in_word.last_byte) begin
        phase      <= PH_HEADER;
        offset     <= '0;
        skip_count <= '0;
        accepted   <= 1'b0;
      end else begin
        phase      <= phase_next;
        offset     <= offset_next;
        skip_count <= skip_count_next;
        accepted   <= accepted_next;
      end
    end
  end

endmodule

// ----- hw/rtl/dnsp_out_buf.sv -----
module dnsp_out_buf
  import dnsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_word_t push_word,
  output logic      can_push,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic      skid_valid;
  out_word_t skid_word;
  logic      pop;
  logic      load_out;

  assign pop      = out_valid && out_ready;
  assign load_out = pop || !out_valid;
  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (skid_valid) begin
        out_word <= skid_word;
        if (push) skid_word <= push_word;
      end else if (push) begin
        out_word <= push_word;
      end
    end else if (push) begin
      skid_word <= push_word;
    end
  end

endmodule

// ----- hw/rtl/dns_a_record_response_parser.sv -----
// Takes one payload byte per cycle unless both output words are held (in_ready low).
// A datagram's result word is registered into the output stage with its final byte.
// A two-word output stage lets bytes keep flowing while one result waits to be taken.
// Synchronous reset returns the parser to the start of a datagram, empties the output
// stage and sets expected_tid to 0, server_port to 53 and listen_enable to 0.
module dns_a_record_response_parser
  import dnsp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_word_t                 in_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_word_t                out_word,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data
);

  cfg_t      cfg;
  logic      in_fire;
  logic      res_valid;
  out_word_t res_word;
  logic      can_push;

  assign in_ready = can_push;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_tid  <= '0;
      cfg.server_port   <= ServerPortReset;
      cfg.listen_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_EXPECTED_TID:  cfg.expected_tid  <= cfg_data;
        REG_SERVER_PORT:   cfg.server_port   <= cfg_data;
        REG_LISTEN_ENABLE: cfg.listen_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dnsp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_fire   (in_fire),
    .in_word   (in_word),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  dnsp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_word (res_word),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
